// File: design/assert_macros.svh
// Assertion macros used by the checker file kpsd_checker.sv.
// No dependencies; clock and reset are taken as clk and rst_n at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication from a condition to a consequence on the next clock.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: design/kpsd_pkg.sv
// Shared types, constants and the key code function for the keypad scanner.
// No dependencies.
`timescale 1ns / 1ps

package kpsd_pkg;

    localparam int ROWS       = 4;
    localparam int COLS       = 4;
    localparam int KEYS       = ROWS * COLS;
    localparam int PHASE_W    = 2;
    localparam int CNT_W      = 8;
    localparam int CODE_W     = 5;

    localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = 8'd5;
    localparam logic [KEYS-1:0]   SNAP_IDLE      = 16'hFFFF;
    localparam logic [CODE_W-1:0] CODE_NONE      = 5'd0;
    localparam logic [CODE_W-1:0] CODE_MANY      = 5'd17;

    typedef enum logic [0:0] {
        OP_SCAN = 1'b0,
        OP_READ = 1'b1
    } kpsd_op_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              changed;
        logic [KEYS-1:0]   key_mask;
        logic [COLS-1:0]   col_drive;
    } kpsd_result_t;

    function automatic logic [CODE_W-1:0] code_of_mask(input logic [KEYS-1:0] m);
        logic [CODE_W-1:0] code;
        code = CODE_NONE;
        if ((m & (m - 16'd1)) != '0)
        begin
            code = CODE_MANY;
        end
        else
        begin
            for (int i = KEYS - 1; i >= 0; i--)
            begin
                if (m[i])
                begin
                    code = CODE_W'(i + 1);
                end
            end
        end
        return code;
    endfunction

endpackage

// File: design/kpsd_core.sv
// Scan and debounce state with the per-transaction update and result logic.
// Depends on kpsd_pkg.
`timescale 1ns / 1ps

module kpsd_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [kpsd_pkg::CNT_W-1:0] cfg_data,
    input  logic                      step,
    input  kpsd_pkg::kpsd_op_t        op,
    input  logic [kpsd_pkg::ROWS-1:0] rows,
    output kpsd_pkg::kpsd_result_t    result
);
    import kpsd_pkg::*;

    logic [CNT_W-1:0]   debounce_len_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [KEYS-1:0]    partial_reg, partial_next;
    logic [KEYS-1:0]    last_reg, last_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEYS-1:0]    stable_reg, stable_next;
    logic               flag_reg, flag_next;
    logic               flag_out;

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        stable_next  = stable_reg;
        flag_next    = flag_reg;
        flag_out     = flag_reg;
        case (op)
            OP_SCAN:
            begin
                partial_next[ROWS*phase_reg +: ROWS] = rows;
                if (phase_reg == PHASE_W'(COLS - 1))
                begin
                    if (partial_next != last_reg)
                    begin
                        count_next = debounce_len_reg;
                    end
                    else if (count_reg != '0)
                    begin
                        count_next = count_reg - 8'd1;
                        if (count_reg == 8'd1)
                        begin
                            stable_next = ~partial_next;
                            flag_next   = 1'b1;
                        end
                    end
                    last_next = partial_next;
                end
                phase_next = phase_reg + 2'd1;
                flag_out   = flag_next;
            end
            OP_READ:
            begin
                flag_next = 1'b0;
            end
            default:
            begin
                flag_out = flag_reg;
            end
        endcase
    end

    assign result.col_drive = ~(4'b0001 << phase_reg);
    assign result.key_mask  = stable_next;
    assign result.changed   = flag_out;
    assign result.key_code  = code_of_mask(stable_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_len_reg <= DEBOUNCE_RESET;
            phase_reg        <= '0;
            partial_reg      <= SNAP_IDLE;
            last_reg         <= SNAP_IDLE;
            count_reg        <= '0;
            stable_reg       <= '0;
            flag_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                debounce_len_reg <= cfg_data;
            end
            if (step)
            begin
                phase_reg   <= phase_next;
                partial_reg <= partial_next;
                last_reg    <= last_next;
                count_reg   <= count_next;
                stable_reg  <= stable_next;
                flag_reg    <= flag_next;
            end
        end
    end

endmodule

// File: design/kpsd_out_reg.sv
// Result register with valid/ready toward the output stream.
// Depends on kpsd_pkg.
`timescale 1ns / 1ps

module kpsd_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  kpsd_pkg::kpsd_result_t result,
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata  // col_drive[3:0], key_mask[19:4],
                                            // changed[20], key_code[25:21], zero above
);
    import kpsd_pkg::*;

    logic         valid_reg, valid_next;
    kpsd_result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, data_reg};

endmodule

// File: design/keypad_4x4_scan_debounce.sv
// Keypad scanner top level: input register, scan/debounce core, result register.
// Depends on kpsd_pkg, kpsd_core and kpsd_out_reg.
// m_tvalid rises when the input register hands a transaction to the result register.
// Throughput: one transaction per cycle, limited only by the output handshake.
// Reset (rst_n, asynchronous, active low): empty stages, column 0, snapshots all ones,
// debounce length 5, mask, counter and changed flag cleared.
`timescale 1ns / 1ps

module keypad_4x4_scan_debounce (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // row_levels[3:0], zero above
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // col_drive[3:0], key_mask[19:4], changed[20],
                                   // key_code[25:21], zero above
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // debounce_len[7:0]
);
    import kpsd_pkg::*;

    logic             in_valid_reg, in_valid_next;
    kpsd_op_t         in_op_reg;
    logic [ROWS-1:0]  in_rows_reg;
    logic             out_free;
    logic             advance;
    logic             accept;
    kpsd_result_t     result;

    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= kpsd_op_t'(s_tuser[0]);
            in_rows_reg <= s_tdata[ROWS-1:0];
        end
    end

    kpsd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .step     (advance),
        .op       (in_op_reg),
        .rows     (in_rows_reg),
        .result   (result)
    );

    kpsd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: design/kpsd_checker.sv
// Port-level checks for the keypad scanner, bound to the top level.
// Depends on kpsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kpsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import kpsd_pkg::*;

    logic              stall;
    logic [COLS-1:0]   col;
    logic [KEYS-1:0]   mask;
    logic [CODE_W-1:0] code;
    logic              no_key;
    logic              multi_key;

    assign stall     = m_tvalid && !m_tready;
    assign col       = m_tdata[3:0];
    assign mask      = m_tdata[19:4];
    assign code      = m_tdata[25:21];
    assign no_key    = (mask == '0);
    assign multi_key = ($countones(mask) > 1);

    `ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASSERT_CLK(a_one_column, !m_tvalid || $countones(col) == 3, "column drive not one-cold")
    `ASSERT_CLK(a_code_none, !m_tvalid || no_key == (code == CODE_NONE), "bad empty key code")
    `ASSERT_CLK(a_code_many, !m_tvalid || multi_key == (code == CODE_MANY), "bad multi-key code")

endmodule

bind keypad_4x4_scan_debounce kpsd_checker u_kpsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/tb_keypad_4x4_scan_debounce.sv
// Self-checking bench for the 4x4 keypad scanner: scan ticks and flag reads in,
// column drive, debounced mask, changed flag and key code out.
// Depends on kpsd_pkg and keypad_4x4_scan_debounce.
`timescale 1ns / 1ps

module tb_keypad_4x4_scan_debounce;

    import kpsd_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_LEN = 80;
    localparam int MAX_PRINTS   = 30;

    typedef struct {
        kpsd_op_t   op;
        logic [3:0] rows;
    } key_txn_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    keypad_4x4_scan_debounce DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // scanner state as the block should hold it
    logic [CNT_W-1:0]   debounce_len = DEBOUNCE_RESET;
    logic [PHASE_W-1:0] scan_col     = '0;
    logic [KEYS-1:0]    row_snap     = SNAP_IDLE;
    logic [KEYS-1:0]    prev_snap    = SNAP_IDLE;
    logic [CNT_W-1:0]   settle_left  = '0;
    logic [KEYS-1:0]    pressed_mask = '0;
    logic               change_pending = 1'b0;

    key_txn_t     key_stimulus[$];
    kpsd_result_t pending_readouts[$];
    logic [7:0]   debounce_writes[$];

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int cfg_done     = 0;
    int latch_count  = 0;
    int settings_run = 0;
    int hold_off_at  = 32'h7FFF_FFFF;

    // stimulus generator's view of the scan column and debounce length
    logic [PHASE_W-1:0] gen_col = '0;
    int                 gen_len = DEBOUNCE_RESET;

    function automatic logic [CODE_W-1:0] key_code_of(input logic [KEYS-1:0] m);
        logic [CODE_W-1:0] c;
        c = CODE_NONE;
        if ($countones(m) > 1)
        begin
            c = CODE_MANY;
        end
        else
        begin
            for (int i = 0; i < KEYS; i++)
            begin
                if (m[i])
                begin
                    c = CODE_W'(i + 1);
                end
            end
        end
        return c;
    endfunction

    function automatic kpsd_result_t scan_and_debounce(input kpsd_op_t op,
                                                       input logic [3:0] rows);
        kpsd_result_t r;
        r.col_drive = ~(4'b0001 << scan_col);
        if (op == OP_SCAN)
        begin
            row_snap[4*scan_col +: 4] = rows;
            if (scan_col == 2'd3)
            begin
                if (row_snap != prev_snap)
                begin
                    settle_left = debounce_len;
                end
                else if (settle_left != 0)
                begin
                    settle_left = settle_left - 1'b1;
                    if (settle_left == 0)
                    begin
                        pressed_mask   = ~row_snap;
                        change_pending = 1'b1;
                        latch_count++;
                    end
                end
                prev_snap = row_snap;
            end
            scan_col  = scan_col + 1'b1;
            r.changed = change_pending;
        end
        else
        begin
            r.changed      = change_pending;
            change_pending = 1'b0;
        end
        r.key_mask = pressed_mask;
        r.key_code = key_code_of(pressed_mask);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_PRINTS)
        begin
            $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h (result %0d)",
                     $time, what, got, want, results_seen);
        end
        errors++;
    endtask

    // config channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                debounce_len = cfg_data;
                cfg_done++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (debounce_writes.size() != 0)
                begin
                    cfg_valid <= 1'b1;
                    cfg_data  <= debounce_writes.pop_front();
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // key transaction driver, bursts with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        key_txn_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pending_readouts.push_back(scan_and_debounce(kpsd_op_t'(s_tuser[0]),
                                                             s_tdata[3:0]));
                items_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (key_stimulus.size() != 0)
                begin
                    nxt = key_stimulus.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, nxt.rows};
                    s_tuser  <= nxt.op;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver: changing stall pattern plus one long hold-off
    int rx_cycles  = 0;
    int stall_mode = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles++;
            if (rx_cycles % 50 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= hold_off_at)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (rx_cycles % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        kpsd_result_t got;
        kpsd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got = kpsd_result_t'(m_tdata[25:0]);
            if (pending_readouts.size() == 0)
            begin
                report_mismatch("unexpected transaction", m_tdata, '0);
            end
            else
            begin
                want = pending_readouts.pop_front();
                if (got.col_drive != want.col_drive)
                    report_mismatch("col_drive", 32'(got.col_drive), 32'(want.col_drive));
                if (got.key_mask != want.key_mask)
                    report_mismatch("key_mask", 32'(got.key_mask), 32'(want.key_mask));
                if (got.changed != want.changed)
                    report_mismatch("changed", 32'(got.changed), 32'(want.changed));
                if (got.key_code != want.key_code)
                    report_mismatch("key_code", 32'(got.key_code), 32'(want.key_code));
                if (m_tdata[31:26] != '0)
                    report_mismatch("tdata padding", 32'(m_tdata[31:26]), '0);
            end
        end
    end

    task automatic queue_read();
        key_txn_t t;
        t.op   = OP_READ;
        t.rows = 4'($urandom_range(0, 15));
        key_stimulus.push_back(t);
    endtask

    task automatic queue_scan(input logic [3:0] rows);
        key_txn_t t;
        t.op   = OP_SCAN;
        t.rows = rows;
        key_stimulus.push_back(t);
        gen_col = gen_col + 1'b1;
    endtask

    // hold a key pattern steady for whole snapshots, reads now and then
    task automatic queue_hold(input logic [KEYS-1:0] mask, input int snaps,
                              input int read_odds);
        logic [KEYS-1:0] lv;
        lv = ~mask;
        for (int s = 0; s < snaps * 4; s++)
        begin
            if (read_odds != 0 && $urandom_range(1, read_odds) == 1)
            begin
                queue_read();
            end
            queue_scan(lv[4*gen_col +: 4]);
        end
    endtask

    task automatic queue_bounce(input logic [KEYS-1:0] mask, input int ticks);
        logic [KEYS-1:0] lv;
        lv = ~mask;
        for (int s = 0; s < ticks; s++)
        begin
            queue_scan(lv[4*gen_col +: 4] ^ 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic queue_noise(input int ticks);
        for (int s = 0; s < ticks; s++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_read();
            end
            else
            begin
                queue_scan(4'($urandom_range(0, 15)));
            end
        end
    endtask

    function automatic logic [KEYS-1:0] pick_mask();
        logic [KEYS-1:0] m;
        case ($urandom_range(0, 4))
            0: m = '0;
            1: m = 16'h0001 << $urandom_range(0, 15);
            2: m = (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
            3: m = 16'($urandom_range(0, 65535));
            default: m = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom());
        endcase
        return m;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (key_stimulus.size() != 0 || s_tvalid || pending_readouts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_debounce(input logic [7:0] len);
        int target;
        target = cfg_done + 1;
        debounce_writes.push_back(len);
        do
            @(negedge clk);
        while (cfg_done < target);
        gen_len = len;
        settings_run++;
    endtask

    task automatic random_phase(input int items);
        int start;
        logic [KEYS-1:0] m;
        start = key_stimulus.size() + items_sent;
        while (key_stimulus.size() + items_sent - start < items)
        begin
            m = pick_mask();
            case ($urandom_range(0, 9))
                0, 1:
                    queue_noise($urandom_range(4, 16));
                2:
                    queue_hold(m, $urandom_range(1, (gen_len > 1) ? gen_len : 1), 6);
                default:
                begin
                    queue_bounce(m, $urandom_range(0, 6));
                    queue_hold(m, gen_len + $urandom_range(1, 4), 10);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        queue_read();
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length of 5, single key at the lowest bit
        queue_read();
        queue_hold(16'h0001, 7, 0);
        queue_read();
        wait_drained();

        // shortest settling: top key, all keys, release, two keys
        set_debounce(8'd1);
        queue_hold(16'h8000, 2, 0);
        queue_read();
        queue_read();
        queue_hold(16'hFFFF, 2, 0);
        queue_hold(16'h0000, 2, 0);
        queue_read();
        queue_hold(16'h0410, 2, 0);
        queue_read();
        wait_drained();

        // zero length never latches
        set_debounce(8'd0);
        queue_hold(16'h0020, 4, 0);
        queue_read();
        queue_hold(16'h0000, 3, 0);
        queue_noise(10);
        wait_drained();

        // longest length counts down, then a new pattern reloads it
        set_debounce(8'd255);
        queue_hold(16'h0200, 16, 0);
        queue_hold(16'h0000, 2, 0);
        queue_read();
        wait_drained();

        set_debounce(8'd2);
        random_phase(100);
        wait_drained();

        set_debounce(8'd3);
        random_phase(100);
        hold_off_at <= results_seen + 40;
        wait_drained();

        set_debounce(8'd1);
        random_phase(70);
        wait_drained();

        set_debounce(8'($urandom_range(4, 8)));
        random_phase(100);
        wait_drained();

        $display("Ran %0d key transactions under %0d debounce settings plus the reset value.",
                 items_sent, settings_run);
        $display("Checked %0d results, %0d debounced state changes latched.",
                 results_seen, latch_count);
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding.", pending_readouts.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: keypad_4x4_scan_debounce.f
+incdir+design
design/kpsd_pkg.sv
design/kpsd_core.sv
design/kpsd_out_reg.sv
design/keypad_4x4_scan_debounce.sv
design/kpsd_checker.sv
dv/tb_keypad_4x4_scan_debounce.sv
